// ----- rtl/core/dgea_pkg.sv -----
// ----------------------------------------------------------------------------
// dgea_pkg
// Shared types, constants and register codes of the double gyre advection unit.
// ----------------------------------------------------------------------------
`default_nettype none

package dgea_pkg;

    // default number of substep cells in the chain
    localparam int MAX_SUBSTEPS_DEF = 8;

    // configuration port
    localparam int PADDR_W = 5;

    localparam logic [2:0] REG_AMP   = 3'd0;
    localparam logic [2:0] REG_EPS   = 3'd1;
    localparam logic [2:0] REG_OMEGA = 3'd2;
    localparam logic [2:0] REG_STEP  = 3'd3;
    localparam logic [2:0] REG_CNT   = 3'd4;

    localparam logic [15:0] AMP_RST   = 16'd6554;
    localparam logic [15:0] EPS_RST   = 16'd16384;
    localparam logic [19:0] OMEGA_RST = 20'd41175;
    localparam logic [15:0] STEP_RST  = 16'd655;
    localparam logic [3:0]  CNT_RST   = 4'd5;

    // fixed point constants
    localparam logic [17:0] PI_Q16         = 18'd205887;
    localparam logic [29:0] INV_TWO_PI_Q32 = 30'd683565276;

    localparam logic signed [23:0] POS_MAX = 24'sh7FFFFF;
    localparam logic signed [23:0] POS_MIN = 24'sh800000;

    // odd polynomial of sin(pi/2*z), Q2.30, lowest order first
    localparam logic signed [31:0] SIN_COEF [5] = '{
        32'sd1686629713, -32'sd693598669, 32'sd85569306, -32'sd5026995, 32'sd172272
    };

    typedef struct packed {
        logic [15:0]        particle_tag;
        logic signed [23:0] start_x;
        logic signed [23:0] start_y;
        logic [23:0]        start_time;
    } t_in_item;

    typedef struct packed {
        logic [15:0]        result_tag;
        logic signed [23:0] end_x;
        logic signed [23:0] end_y;
        logic               clipped;
    } t_out_item;

    // particle state handed from cell to cell
    typedef struct packed {
        logic [15:0]        tag;
        logic signed [23:0] x;
        logic signed [23:0] y;
        logic [23:0]        t;
        logic               flag;
    } t_ptcl;

    // flow settings seen by every cell
    typedef struct packed {
        logic [19:0] omega;
        logic [15:0] eps;
        logic [15:0] step;
        logic [17:0] pia;
    } t_cell_cfg;

endpackage

`default_nettype wire

// ----- rtl/core/dgea_stream_if.sv -----
// ----------------------------------------------------------------------------
// dgea_stream_if
// Valid/ready stream channel carrying one payload item per request.
// ----------------------------------------------------------------------------
`default_nettype none

interface dgea_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/dgea_sin.sv -----
// ----------------------------------------------------------------------------
// dgea_sin
// Pipelined sine of a 16-bit turn phase, signed Q1.16 result, six stages.
// ----------------------------------------------------------------------------
`default_nettype none

module dgea_sin (
    input  wire logic               i_clk,
    input  wire logic               i_en,
    input  wire logic [15:0]        i_phase,
    output logic signed [17:0]      o_sine
);
    import dgea_pkg::*;

    function automatic logic signed [31:0] horner_step(
        input logic signed [31:0] c,
        input logic signed [31:0] p,
        input logic [30:0]        z2
    );
        logic signed [63:0] prod;
        prod = 64'(p) * 64'(signed'({1'b0, z2}));
        horner_step = c + $signed(prod[61:30]);
    endfunction

    logic [1:0]         w_quad;
    logic [14:0]        w_r;
    logic [29:0]        w_rr;
    logic [30:0]        w_z2;

    logic [30:0]        r_z2 [0:3];
    logic [14:0]        r_r  [0:4];
    logic [1:0]         r_q  [0:4];
    logic signed [31:0] r_p  [0:3];
    logic signed [17:0] r_s;

    logic signed [47:0] w_prod;
    logic signed [47:0] w_sc;
    logic [33:0]        w_pos;
    logic [34:0]        w_rnd;
    logic [20:0]        w_mag;
    logic [16:0]        w_sat;
    logic signed [17:0] n_s;

    // quadrant fold and z^2
    assign w_quad = i_phase[15:14];
    assign w_r    = w_quad[0] ? (15'h4000 - {1'b0, i_phase[13:0]}) : {1'b0, i_phase[13:0]};
    assign w_rr   = 30'(w_r) * 30'(w_r);
    assign w_z2   = {w_rr[28:0], 2'b00};

    // final multiply, round half up and clamp
    always_comb begin
        w_prod = 48'(r_p[3]) * 48'(signed'({1'b0, r_r[4]}));
        w_sc   = w_prod >>> 14;
        w_pos  = w_sc[47] ? 34'd0 : w_sc[33:0];
        w_rnd  = 35'(w_pos) + 35'd8192;
        w_mag  = w_rnd[34:14];
        w_sat  = (w_mag > 21'd65536) ? 17'd65536 : w_mag[16:0];
        n_s    = r_q[4][1] ? (18'sd0 - signed'({1'b0, w_sat})) : signed'({1'b0, w_sat});
    end

    // horner stages
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_z2[0] <= w_z2;
            r_r[0]  <= w_r;
            r_q[0]  <= w_quad;
            for (int k = 1; k < 4; k++) begin
                r_z2[k] <= r_z2[k-1];
            end
            for (int k = 1; k < 5; k++) begin
                r_r[k] <= r_r[k-1];
                r_q[k] <= r_q[k-1];
            end
            r_p[0] <= horner_step(SIN_COEF[3], SIN_COEF[4], r_z2[0]);
            r_p[1] <= horner_step(SIN_COEF[2], r_p[0], r_z2[1]);
            r_p[2] <= horner_step(SIN_COEF[1], r_p[1], r_z2[2]);
            r_p[3] <= horner_step(SIN_COEF[0], r_p[2], r_z2[3]);
            r_s    <= n_s;
        end
    end

    assign o_sine = r_s;

endmodule

`default_nettype wire

// ----- rtl/core/dgea_cell.sv -----
// ----------------------------------------------------------------------------
// dgea_cell
// One forward Euler substep of the double gyre flow, 22 pipeline stages.
// ----------------------------------------------------------------------------
`default_nettype none

module dgea_cell (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_en,
    input  wire logic                 i_active,
    input  wire dgea_pkg::t_cell_cfg  i_cfg,
    input  wire logic                 i_valid,
    input  wire dgea_pkg::t_ptcl      i_item,
    output logic                      o_valid,
    output dgea_pkg::t_ptcl           o_item
);
    import dgea_pkg::*;

    logic [21:0]        r_vld;
    t_ptcl              r_pipe [0:20];
    t_ptcl              r_out;
    t_ptcl              n_out;

    logic [43:0]        w_angp;
    logic [27:0]        r_ang;
    logic [57:0]        w_wp;
    logic [15:0]        r_wph;
    logic signed [17:0] w_sw;

    logic signed [34:0] w_esp;
    logic signed [47:0] w_xx;
    logic signed [17:0] r_es;
    logic [26:0]        r_x2;

    logic signed [45:0] w_ap;
    logic signed [18:0] w_k;
    logic signed [42:0] w_bp;
    logic signed [41:0] w_exp;
    logic signed [27:0] r_a;
    logic signed [26:0] r_b;
    logic signed [24:0] r_ex;
    logic signed [17:0] r_es10;

    logic signed [28:0] w_f;
    logic signed [26:0] w_g;
    logic [15:0]        r_fph;
    logic [15:0]        r_yph;
    logic signed [26:0] r_g [0:8];

    logic signed [17:0] w_sf, w_cf, w_sy, w_cy;
    logic signed [35:0] w_t1p, w_c1p;
    logic signed [17:0] r_t1, r_c1;
    logic signed [36:0] w_pup, w_pvp;
    logic signed [19:0] r_pt1, r_t2;
    logic signed [46:0] w_vp;
    logic signed [23:0] r_u;
    logic signed [28:0] r_v;
    logic signed [40:0] w_dxp;
    logic signed [46:0] w_dyp;
    logic signed [24:0] r_dx;
    logic signed [28:0] r_dy;
    logic signed [29:0] w_nx, w_ny;

    // time phase: omega*t, then turns
    assign w_angp = 44'(i_cfg.omega) * 44'(i_item.t);
    assign w_wp   = 58'(r_ang) * 58'(INV_TWO_PI_Q32);

    dgea_sin u_sin_w (.i_clk(i_clk), .i_en(i_en), .i_phase(r_wph), .o_sine(w_sw));

    // es and x^2
    assign w_esp = 35'(signed'({1'b0, i_cfg.eps})) * 35'(w_sw);
    assign w_xx  = 48'(r_pipe[7].x) * 48'(r_pipe[7].x);

    // f terms and gradient term
    assign w_ap  = 46'(r_es) * 46'(signed'({1'b0, r_x2}));
    assign w_k   = 19'sd65536 - (19'(r_es) <<< 1);
    assign w_bp  = 43'(w_k) * 43'(r_pipe[8].x);
    assign w_exp = 42'(r_es) * 42'(r_pipe[8].x);
    assign w_f   = 29'(r_a) + 29'(r_b);
    assign w_g   = (27'(r_ex) <<< 1) - (27'(r_es10) <<< 5) + 27'sd1048576;

    // trig of pi*f and pi*y
    dgea_sin u_sin_f (.i_clk(i_clk), .i_en(i_en), .i_phase(r_fph), .o_sine(w_sf));
    dgea_sin u_cos_f (.i_clk(i_clk), .i_en(i_en), .i_phase(r_fph + 16'h4000), .o_sine(w_cf));
    dgea_sin u_sin_y (.i_clk(i_clk), .i_en(i_en), .i_phase(r_yph), .o_sine(w_sy));
    dgea_sin u_cos_y (.i_clk(i_clk), .i_en(i_en), .i_phase(r_yph + 16'h4000), .o_sine(w_cy));

    // velocity products
    assign w_t1p = 36'(w_sf) * 36'(w_cy);
    assign w_c1p = 36'(w_cf) * 36'(w_sy);
    assign w_pup = 37'(signed'({1'b0, i_cfg.pia})) * 37'(r_t1);
    assign w_pvp = 37'(signed'({1'b0, i_cfg.pia})) * 37'(r_c1);
    assign w_vp  = 47'(r_g[8]) * 47'(r_t2);

    // displacement
    assign w_dxp = 41'(signed'({1'b0, i_cfg.step})) * 41'(r_u);
    assign w_dyp = 47'(signed'({1'b0, i_cfg.step})) * 47'(r_v);

    // position update with saturation, bypass when the cell is unused
    always_comb begin
        n_out = r_pipe[20];
        w_nx  = 30'(r_pipe[20].x) + 30'(r_dx);
        w_ny  = 30'(r_pipe[20].y) + 30'(r_dy);
        if (i_active) begin
            if (w_nx > 30'(POS_MAX)) begin
                n_out.x    = POS_MAX;
                n_out.flag = 1'b1;
            end else if (w_nx < 30'(POS_MIN)) begin
                n_out.x    = POS_MIN;
                n_out.flag = 1'b1;
            end else begin
                n_out.x = w_nx[23:0];
            end
            if (w_ny > 30'(POS_MAX)) begin
                n_out.y    = POS_MAX;
                n_out.flag = 1'b1;
            end else if (w_ny < 30'(POS_MIN)) begin
                n_out.y    = POS_MIN;
                n_out.flag = 1'b1;
            end else begin
                n_out.y = w_ny[23:0];
            end
            n_out.t = r_pipe[20].t + 24'(i_cfg.step);
        end
    end

    // valid pipeline
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[20:0], i_valid};
        end
    end

    // datapath stages
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pipe[0] <= i_item;
            for (int k = 1; k < 21; k++) begin
                r_pipe[k] <= r_pipe[k-1];
            end
            r_ang  <= w_angp[43:16];
            r_wph  <= w_wp[47:32];
            r_es   <= w_esp[33:16];
            r_x2   <= w_xx[46:20];
            r_a    <= w_ap[43:16];
            r_b    <= w_bp[42:16];
            r_ex   <= w_exp[40:16];
            r_es10 <= r_es;
            r_fph  <= w_f[20:5];
            r_yph  <= r_pipe[9].y[20:5];
            r_g[0] <= w_g;
            for (int k = 1; k < 9; k++) begin
                r_g[k] <= r_g[k-1];
            end
            r_t1   <= w_t1p[33:16];
            r_c1   <= w_c1p[33:16];
            r_pt1  <= w_pup[35:16];
            r_t2   <= w_pvp[35:16];
            r_u    <= 24'sd0 - (24'(r_pt1) <<< 4);
            r_v    <= w_vp[44:16];
            r_dx   <= w_dxp[40:16];
            r_dy   <= w_dyp[44:16];
            r_out  <= n_out;
        end
    end

    assign o_valid = r_vld[21];
    assign o_item  = r_out;

`ifndef ASSERT_OFF
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_en && o_valid |=> $stable(o_item) && o_valid)
        else $error("cell output changed while stalled");

    a_sine_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[7] |-> (w_sw <= 18'sd65536) && (w_sw >= -18'sd65536))
        else $error("time sine out of range");

    a_flag_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_en && r_vld[20] && r_pipe[20].flag |=> o_item.flag)
        else $error("clip flag cleared");

    a_bypass_tag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_en && r_vld[20] |=> o_item.tag == $past(r_pipe[20].tag))
        else $error("particle tag altered");
`endif

endmodule

`default_nettype wire

// ----- rtl/core/double_gyre_euler_advection_unit.sv -----
// ----------------------------------------------------------------------------
// double_gyre_euler_advection_unit
// Forward Euler particle advection in the double gyre flow, chain of cells.
// ----------------------------------------------------------------------------
//  channel   dir  kind     payload
//  i_part    in   stream   particle_tag, start_x, start_y, start_time
//  o_res     out  stream   result_tag, end_x, end_y, clipped
//  apb       in   config   amplitude, perturbation, angular_rate, time_step,
//                          substep_count
//
//  One particle is taken per cycle while the chain is not held.
//  The chain has MAX_SUBSTEPS cells of 22 stages each (sine pipelines and
//  multiplier stages); cells past substep_count pass the particle unchanged.
//  Reset clears valid bits and loads config defaults; no clearing pass needed.
//  A result not taken holds the whole chain, and i_part.ready drops with it.
// ----------------------------------------------------------------------------
`default_nettype none

module double_gyre_euler_advection_unit #(
    parameter int MAX_SUBSTEPS = dgea_pkg::MAX_SUBSTEPS_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    dgea_stream_if.sink                        i_part,
    dgea_stream_if.source                      o_res,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [dgea_pkg::PADDR_W-1:0]  paddr,
    input  wire logic [31:0]                   pwdata,
    output logic [31:0]                        prdata,
    output logic                               pready
);
    import dgea_pkg::*;

    logic [15:0] r_amp;
    logic [15:0] r_eps;
    logic [19:0] r_omega;
    logic [15:0] r_step;
    logic [3:0]  r_cnt;
    logic [17:0] r_pia;
    logic [33:0] w_piap;

    t_cell_cfg             w_cfg;
    t_ptcl                 w_item [0:MAX_SUBSTEPS];
    logic [MAX_SUBSTEPS:0] w_vld;
    logic [MAX_SUBSTEPS-1:0] w_active;
    logic                  w_en;

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_amp   <= AMP_RST;
            r_eps   <= EPS_RST;
            r_omega <= OMEGA_RST;
            r_step  <= STEP_RST;
            r_cnt   <= CNT_RST;
        end else if (psel && penable && pwrite) begin
            case (paddr[4:2])
                REG_AMP:   r_amp   <= pwdata[15:0];
                REG_EPS:   r_eps   <= pwdata[15:0];
                REG_OMEGA: r_omega <= pwdata[19:0];
                REG_STEP:  r_step  <= pwdata[15:0];
                REG_CNT:   r_cnt   <= pwdata[3:0];
                default:   ;
            endcase
        end
    end

    // register reads
    always_comb begin
        case (paddr[4:2])
            REG_AMP:   prdata = 32'(r_amp);
            REG_EPS:   prdata = 32'(r_eps);
            REG_OMEGA: prdata = 32'(r_omega);
            REG_STEP:  prdata = 32'(r_step);
            REG_CNT:   prdata = 32'(r_cnt);
            default:   prdata = 32'd0;
        endcase
    end

    assign pready = 1'b1;

    // pi*A, refreshed every cycle
    assign w_piap = 34'(r_amp) * 34'(PI_Q16);

    always_ff @(posedge i_clk) begin
        r_pia <= w_piap[33:16];
    end

    assign w_cfg = '{omega: r_omega, eps: r_eps, step: r_step, pia: r_pia};

    // chain advances unless a finished result waits
    assign w_en         = !w_vld[MAX_SUBSTEPS] || o_res.ready;
    assign i_part.ready = w_en;

    assign w_vld[0]  = i_part.valid;
    assign w_item[0] = '{tag:  i_part.data.particle_tag,
                         x:    i_part.data.start_x,
                         y:    i_part.data.start_y,
                         t:    i_part.data.start_time,
                         flag: 1'b0};

    // substep cells
    for (genvar g = 0; g < MAX_SUBSTEPS; g++) begin : g_cell
        assign w_active[g] = ({1'b0, r_cnt} > 5'(g));

        dgea_cell u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_en     (w_en),
            .i_active (w_active[g]),
            .i_cfg    (w_cfg),
            .i_valid  (w_vld[g]),
            .i_item   (w_item[g]),
            .o_valid  (w_vld[g+1]),
            .o_item   (w_item[g+1])
        );
    end

    // result request
    assign o_res.valid           = w_vld[MAX_SUBSTEPS];
    assign o_res.data.result_tag = w_item[MAX_SUBSTEPS].tag;
    assign o_res.data.end_x      = w_item[MAX_SUBSTEPS].x;
    assign o_res.data.end_y      = w_item[MAX_SUBSTEPS].y;
    assign o_res.data.clipped    = w_item[MAX_SUBSTEPS].flag;

endmodule

`default_nettype wire
